### src/obm_pkg.sv
// shared types and codes for the order book matcher
package obm_pkg;

  localparam logic [2:0] ACT_ADD_LIMIT  = 3'd0;
  localparam logic [2:0] ACT_ADD_MARKET = 3'd1;
  localparam logic [2:0] ACT_CANCEL     = 3'd2;
  localparam logic [2:0] ACT_MODIFY     = 3'd3;
  localparam logic [2:0] ACT_REDUCE     = 3'd4;
  localparam logic [2:0] ACT_REPLACE    = 3'd5;

  localparam logic [2:0] EV_ACCEPTED  = 3'd0;
  localparam logic [2:0] EV_REJECTED  = 3'd1;
  localparam logic [2:0] EV_FILL      = 3'd2;
  localparam logic [2:0] EV_BOOK      = 3'd3;
  localparam logic [2:0] EV_CANCELLED = 3'd4;
  localparam logic [2:0] EV_MODIFIED  = 3'd5;

  localparam logic [2:0] RJ_DUP   = 3'd0;
  localparam logic [2:0] RJ_BADQ  = 3'd1;
  localparam logic [2:0] RJ_BADP  = 3'd2;
  localparam logic [2:0] RJ_UNK   = 3'd3;
  localparam logic [2:0] RJ_INSUF = 3'd4;
  localparam logic [2:0] RJ_FULL  = 3'd5;

  typedef struct packed {
    logic [2:0]         action;
    logic [31:0]        order_id;
    logic [31:0]        new_order_id;
    logic               order_side;
    logic signed [31:0] order_price;
    logic signed [31:0] order_quantity;
  } in_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [31:0] event_order_id;
    logic [31:0] event_resting_id;
    logic        event_side;
    logic [30:0] event_price;
    logic [34:0] event_quantity;
    logic [2:0]  reject_code;
    logic        last_event;
  } out_t;

  typedef struct packed {
    logic [31:0] id;
    logic        side;
    logic [30:0] price;
    logic [30:0] qty;
    logic [63:0] arrival;
  } slot_t;

endpackage

### src/obm_ram.sv
// generic single write port ram with registered read
module obm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/limit_order_book_matcher_core.sv
// order book matcher top level: slot store, scan sequencer and event output
// scans: every lookup, best-price, free-slot or level-sum scan reads all MAX_ORDERS slots
// an item takes 1 to fills+6 scans with control states between them; an unused action runs no scan
// throughput: one item at a time; in_ready only while idle; output stalls hold the sequencer
// events leave through a one-entry hold stage and an output register
// reset: synchronous, empties the store (valid bits cleared), arrival count zero, no event pending
module limit_order_book_matcher_core #(
  parameter int MAX_ORDERS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  obm_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output obm_pkg::out_t out_item
);
  import obm_pkg::*;

  localparam int AW = $clog2(MAX_ORDERS);
  localparam int CW = $clog2(MAX_ORDERS + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(MAX_ORDERS);
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_ORDERS - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_FOUND = 4'd2;
  localparam logic [3:0] S_MDEC  = 4'd3;
  localparam logic [3:0] S_FREE  = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_LVL   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;

  localparam logic [1:0] K_FIND  = 2'd0;
  localparam logic [1:0] K_BEST  = 2'd1;
  localparam logic [1:0] K_LEVEL = 2'd2;
  localparam logic [1:0] K_FREE  = 2'd3;

  logic [3:0]         state, state_next;
  logic [1:0]         kind, kind_next;
  logic               scan_go;
  logic [2:0]         act;
  logic [31:0]        cur_id, alt_id;
  logic               a_side;
  logic signed [31:0] price, qty;
  logic [30:0]        rem;
  logic               readd;
  logic [CW-1:0]      issue_cnt;
  logic               rd_ok;
  logic [AW-1:0]      rd_idx;
  logic               hit_ok;
  logic [AW-1:0]      hit_idx;
  slot_t              hit;
  logic [34:0]        acc;
  logic               lvl_side;
  logic [30:0]        lvl_price;
  logic               have_level;
  logic [63:0]        arrival;
  logic [MAX_ORDERS-1:0] valid;

  out_t  pend, res, ev, pend_out;
  logic  pend_valid, res_valid, res_free, can_emit, ev_fire;

  logic  we;
  slot_t wdata, rd;
  logic [$bits(slot_t)-1:0] ram_rdata;

  logic qpos, ppos, peq, qle, insuf, inplace;
  logic f_rej, f_level, f_emit;
  logic [2:0] f_code;
  logic drained, go_ok, better;
  logic [30:0] traded;

  function automatic out_t mk_ev(input logic [2:0] k, input logic [31:0] id,
                                 input logic [31:0] rid, input logic sd,
                                 input logic [30:0] pr, input logic [34:0] q,
                                 input logic [2:0] code);
    out_t e;
    e.event_kind       = k;
    e.event_order_id   = id;
    e.event_resting_id = rid;
    e.event_side       = sd;
    e.event_price      = pr;
    e.event_quantity   = q;
    e.reject_code      = code;
    e.last_event       = 1'b0;
    return e;
  endfunction

  obm_ram #(.WIDTH($bits(slot_t)), .DEPTH(MAX_ORDERS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (hit_idx),
    .wdata (wdata),
    .raddr (issue_cnt[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd        = slot_t'(ram_rdata);
  assign res_free  = !res_valid || out_ready;
  assign can_emit  = !pend_valid || res_free;
  assign in_ready  = (state == S_IDLE);
  assign out_valid = res_valid;
  assign out_item  = res;

  always_comb begin
    qpos    = !qty[31] && (qty[30:0] != 31'd0);
    ppos    = !price[31] && (price[30:0] != 31'd0);
    peq     = !price[31] && (price[30:0] == hit.price);
    qle     = qty[30:0] <= hit.qty;
    insuf   = hit.qty < qty[30:0];
    inplace = peq && qle;
    f_rej   = 1'b0;
    f_code  = RJ_DUP;
    f_level = 1'b0;
    case (act)
      ACT_ADD_LIMIT: begin
        if (hit_ok) begin
          f_rej = 1'b1; f_code = RJ_DUP;
        end else if (!qpos) begin
          f_rej = 1'b1; f_code = RJ_BADQ;
        end else if (!ppos) begin
          f_rej = 1'b1; f_code = RJ_BADP;
        end
      end
      ACT_ADD_MARKET: begin
        if (hit_ok) begin
          f_rej = 1'b1; f_code = RJ_DUP;
        end else if (!qpos) begin
          f_rej = 1'b1; f_code = RJ_BADQ;
        end
      end
      ACT_CANCEL: begin
        if (!hit_ok) begin
          f_rej = 1'b1; f_code = RJ_UNK;
        end else begin
          f_level = 1'b1;
        end
      end
      ACT_REPLACE: begin
        f_level = hit_ok;
      end
      ACT_MODIFY: begin
        if (!hit_ok) begin
          f_rej = 1'b1; f_code = RJ_UNK;
        end else if (!qpos) begin
          f_rej = 1'b1; f_code = RJ_BADQ;
        end else begin
          f_level = 1'b1;
        end
      end
      ACT_REDUCE: begin
        if (!hit_ok) begin
          f_rej = 1'b1; f_code = RJ_UNK;
        end else if (!qpos) begin
          f_rej = 1'b1; f_code = RJ_BADQ;
        end else if (insuf) begin
          f_rej = 1'b1; f_code = RJ_INSUF;
        end else begin
          f_level = 1'b1;
        end
      end
      default: ;
    endcase
    f_emit = f_rej || (f_level && (act == ACT_CANCEL || act == ACT_REPLACE ||
                                   (act == ACT_MODIFY && inplace)));

    drained = have_level && (!hit_ok || hit.price != lvl_price);
    go_ok   = hit_ok && (act == ACT_ADD_MARKET ||
                         (a_side ? price[30:0] <= hit.price : price[30:0] >= hit.price));
    traded  = (rem < hit.qty) ? rem : hit.qty;
    better  = (a_side ? rd.price > hit.price : rd.price < hit.price) ||
              (rd.price == hit.price && rd.arrival < hit.arrival);

    ev      = mk_ev(EV_ACCEPTED, cur_id, 32'd0, 1'b0, 31'd0, 35'd0, RJ_DUP);
    ev_fire = 1'b0;
    we      = 1'b0;
    wdata   = hit;
    case (state)
      S_FOUND: begin
        if (f_rej) begin
          ev = mk_ev(EV_REJECTED, cur_id, 32'd0, 1'b0, 31'd0, 35'd0, f_code);
        end else if (act == ACT_MODIFY) begin
          ev = mk_ev(EV_MODIFIED, cur_id, 32'd0, 1'b0, 31'd0, {4'd0, qty[30:0]}, RJ_DUP);
        end else begin
          ev = mk_ev(EV_CANCELLED, cur_id, 32'd0, 1'b0, 31'd0, {4'd0, hit.qty}, RJ_DUP);
        end
        ev_fire = f_emit && can_emit;
        if (f_level && act == ACT_MODIFY && inplace) begin
          wdata.qty = qty[30:0];
          we        = can_emit;
        end else if (f_level && act == ACT_REDUCE) begin
          wdata.qty = hit.qty - qty[30:0];
          we        = 1'b1;
        end
      end
      S_MDEC: begin
        if (drained) begin
          ev      = mk_ev(EV_BOOK, cur_id, 32'd0, lvl_side, lvl_price, 35'd0, RJ_DUP);
          ev_fire = can_emit;
        end else if (go_ok) begin
          ev        = mk_ev(EV_FILL, cur_id, hit.id, a_side, hit.price, {4'd0, traded}, RJ_DUP);
          ev_fire   = can_emit;
          wdata.qty = hit.qty - traded;
          we        = can_emit;
        end
      end
      S_FREE: begin
        ev      = mk_ev(EV_REJECTED, cur_id, 32'd0, 1'b0, 31'd0, 35'd0, RJ_FULL);
        ev_fire = !hit_ok && can_emit;
        wdata   = '{id: cur_id, side: a_side, price: price[30:0], qty: rem, arrival: arrival};
        we      = hit_ok;
      end
      S_ACC: begin
        ev_fire = can_emit;
      end
      S_LVL: begin
        ev      = mk_ev(EV_BOOK, cur_id, 32'd0, lvl_side, lvl_price, acc, RJ_DUP);
        ev_fire = can_emit;
      end
      default: ;
    endcase

    pend_out            = pend;
    pend_out.last_event = !ev_fire;
  end

  always_comb begin
    state_next = state;
    kind_next  = kind;
    scan_go    = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_item.action inside {[ACT_ADD_LIMIT:ACT_REPLACE]}) begin
            scan_go = 1'b1; kind_next = K_FIND;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_SCAN: begin
        if (rd_ok && rd_idx == LAST_IDX) begin
          case (kind)
            K_FIND:  state_next = S_FOUND;
            K_BEST:  state_next = S_MDEC;
            K_LEVEL: state_next = S_LVL;
            default: state_next = S_FREE;
          endcase
        end
      end
      S_FOUND: begin
        if (!f_emit || can_emit) begin
          if (f_level) begin
            scan_go = 1'b1; kind_next = K_LEVEL;
          end else if (!f_rej && (act == ACT_ADD_LIMIT || act == ACT_ADD_MARKET)) begin
            scan_go = 1'b1; kind_next = K_BEST;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_MDEC: begin
        if (drained) begin
          state_next = S_MDEC;
        end else if (go_ok) begin
          if (can_emit) begin
            scan_go   = 1'b1;
            kind_next = (rem == traded) ? K_LEVEL : K_BEST;
          end
        end else if (act == ACT_ADD_MARKET) begin
          state_next = S_FIN;
        end else begin
          scan_go = 1'b1; kind_next = K_FREE;
        end
      end
      S_FREE: begin
        if (hit_ok) begin
          state_next = S_ACC;
        end else if (can_emit) begin
          state_next = S_FIN;
        end
      end
      S_ACC: begin
        if (can_emit) begin
          scan_go = 1'b1; kind_next = K_LEVEL;
        end
      end
      S_LVL: begin
        if (can_emit) begin
          if (readd) begin
            scan_go = 1'b1; kind_next = K_FIND;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!pend_valid || res_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (scan_go) begin
      state_next = S_SCAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      kind       <= K_FIND;
      valid      <= '0;
      arrival    <= 64'd0;
      readd      <= 1'b0;
      have_level <= 1'b0;
      rd_ok      <= 1'b0;
      hit_ok     <= 1'b0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      kind  <= kind_next;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            act        <= in_item.action;
            cur_id     <= in_item.order_id;
            alt_id     <= in_item.new_order_id;
            a_side     <= in_item.order_side;
            price      <= in_item.order_price;
            qty        <= in_item.order_quantity;
            rem        <= in_item.order_quantity[30:0];
            readd      <= 1'b0;
            have_level <= 1'b0;
          end
        end
        S_SCAN: begin
          if (issue_cnt != LAST_CNT) begin
            issue_cnt <= issue_cnt + 1'b1;
            rd_ok     <= 1'b1;
            rd_idx    <= issue_cnt[AW-1:0];
          end else begin
            rd_ok <= 1'b0;
          end
          if (rd_ok) begin
            case (kind)
              K_FIND: begin
                if (!hit_ok && valid[rd_idx] && rd.id == cur_id) begin
                  hit_ok <= 1'b1; hit_idx <= rd_idx; hit <= rd;
                end
              end
              K_BEST: begin
                if (valid[rd_idx] && rd.side != a_side && (!hit_ok || better)) begin
                  hit_ok <= 1'b1; hit_idx <= rd_idx; hit <= rd;
                end
              end
              K_LEVEL: begin
                if (valid[rd_idx] && rd.side == lvl_side && rd.price == lvl_price) begin
                  acc <= acc + {4'd0, rd.qty};
                end
              end
              default: begin
                if (!hit_ok && !valid[rd_idx]) begin
                  hit_ok <= 1'b1; hit_idx <= rd_idx;
                end
              end
            endcase
          end
        end
        S_FOUND: begin
          if ((!f_emit || can_emit) && f_level) begin
            lvl_side  <= hit.side;
            lvl_price <= hit.price;
            case (act)
              ACT_CANCEL: valid[hit_idx] <= 1'b0;
              ACT_REPLACE: begin
                valid[hit_idx] <= 1'b0;
                readd          <= 1'b1;
                a_side         <= hit.side;
              end
              ACT_MODIFY: begin
                if (!inplace) begin
                  valid[hit_idx] <= 1'b0;
                  readd          <= 1'b1;
                  alt_id         <= cur_id;
                  a_side         <= hit.side;
                end
              end
              ACT_REDUCE: begin
                if (hit.qty == qty[30:0]) begin
                  valid[hit_idx] <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        S_MDEC: begin
          if (drained) begin
            if (can_emit) begin
              have_level <= 1'b0;
            end
          end else if (go_ok && can_emit) begin
            rem        <= rem - traded;
            have_level <= 1'b1;
            lvl_side   <= ~a_side;
            lvl_price  <= hit.price;
            if (hit.qty == traded) begin
              valid[hit_idx] <= 1'b0;
            end
          end
        end
        S_FREE: begin
          if (hit_ok) begin
            valid[hit_idx] <= 1'b1;
            arrival        <= arrival + 64'd1;
            lvl_side       <= a_side;
            lvl_price      <= price[30:0];
          end
        end
        S_LVL: begin
          if (can_emit && readd) begin
            readd  <= 1'b0;
            act    <= ACT_ADD_LIMIT;
            cur_id <= alt_id;
          end
        end
        default: ;
      endcase

      if (scan_go) begin
        issue_cnt <= '0;
        rd_ok     <= 1'b0;
        hit_ok    <= 1'b0;
        acc       <= 35'd0;
      end

      // hold stage and output register
      if (ev_fire) begin
        pend       <= ev;
        pend_valid <= 1'b1;
      end else if (state == S_FIN && res_free) begin
        pend_valid <= 1'b0;
      end
      if (pend_valid && (ev_fire || (state == S_FIN && res_free))) begin
        res       <= pend_out;
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !pend_valid)
    else $error("event still held while idle");

  a_best_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_MDEC && hit_ok) |-> valid[hit_idx])
    else $error("best slot not valid");

  a_arrival_step: assert property (@(posedge clk) disable iff (rst)
    (state != S_FREE || !hit_ok) |=> $stable(arrival))
    else $error("arrival count moved without a placement");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    ev_fire |-> (!pend_valid || res_free))
    else $error("event overwrote a held event");
`endif
endmodule

### tb/tb_top.sv
// testbench for the order book matcher: directed and random order flow checked against a book model
`timescale 1ns / 1ps
module tb_top;
  import obm_pkg::*;

  localparam int NSLOT = 16;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_item;

  limit_order_book_matcher_core #(.MAX_ORDERS(NSLOT)) uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // book model
  logic        bk_valid [NSLOT];
  logic [31:0] bk_id    [NSLOT];
  logic        bk_side  [NSLOT];
  logic [30:0] bk_price [NSLOT];
  logic [30:0] bk_qty   [NSLOT];
  logic [63:0] bk_arr   [NSLOT];
  logic [63:0] arr_count;

  out_t pending_events[$];
  out_t step_events[$];
  int errors = 0;
  int n_events = 0;
  int n_fills = 0;
  int n_items = 0;
  longint cycles = 0;
  int in_gap_max = 3;
  int out_gap_max = 3;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic void push_event(logic [2:0] kind, logic [31:0] id, logic [31:0] rid,
                                     logic side, logic [30:0] price, logic [34:0] qty,
                                     logic [2:0] code);
    out_t e;
    e.event_kind = kind;
    e.event_order_id = id;
    e.event_resting_id = rid;
    e.event_side = side;
    e.event_price = price;
    e.event_quantity = qty;
    e.reject_code = code;
    e.last_event = 1'b0;
    if (step_events.size() < 36) step_events.insert(step_events.size(), e);
  endfunction

  function automatic int find_order(logic [31:0] id);
    for (int i = 0; i < NSLOT; i++)
      if (bk_valid[i] && bk_id[i] == id) return i;
    return -1;
  endfunction

  function automatic logic [34:0] level_sum(logic side, logic [30:0] price);
    logic [34:0] t;
    t = '0;
    for (int i = 0; i < NSLOT; i++)
      if (bk_valid[i] && bk_side[i] == side && bk_price[i] == price) t += bk_qty[i];
    return t;
  endfunction

  function automatic logic [31:0] cross_book(logic [31:0] id, logic side, bit limited,
                                             longint lim, logic [31:0] rem);
    logic opp;
    int best;
    int old;
    logic [30:0] bp;
    logic [31:0] traded;
    opp = ~side;
    while (rem > 0) begin
      best = -1;
      bp = '0;
      for (int i = 0; i < NSLOT; i++) begin
        if (!bk_valid[i] || bk_side[i] != opp) continue;
        if (best < 0 || (side == 1'b0 ? bk_price[i] < bp : bk_price[i] > bp)) begin
          best = i;
          bp = bk_price[i];
        end
      end
      if (best < 0) break;
      if (limited && !(side == 1'b0 ? lim >= longint'(bp) : lim <= longint'(bp))) break;
      while (rem > 0) begin
        old = -1;
        for (int i = 0; i < NSLOT; i++)
          if (bk_valid[i] && bk_side[i] == opp && bk_price[i] == bp &&
              (old < 0 || bk_arr[i] < bk_arr[old])) old = i;
        if (old < 0) break;
        traded = (rem < 32'(bk_qty[old])) ? rem : 32'(bk_qty[old]);
        push_event(EV_FILL, id, bk_id[old], side, bp, 35'(traded), 3'd0);
        rem -= traded;
        bk_qty[old] -= traded[30:0];
        if (bk_qty[old] == 0) bk_valid[old] = 1'b0;
      end
      push_event(EV_BOOK, id, '0, opp, bp, level_sum(opp, bp), 3'd0);
    end
    return rem;
  endfunction

  function automatic void place_limit(logic [31:0] id, logic side, longint price,
                                      longint qty);
    logic [31:0] rem;
    int f;
    f = -1;
    if (find_order(id) >= 0) begin push_event(EV_REJECTED, id, 0, 0, 0, 0, RJ_DUP); return; end
    if (qty <= 0) begin push_event(EV_REJECTED, id, 0, 0, 0, 0, RJ_BADQ); return; end
    if (price <= 0) begin push_event(EV_REJECTED, id, 0, 0, 0, 0, RJ_BADP); return; end
    rem = cross_book(id, side, 1'b1, price, 32'(qty));
    if (rem == 0) return;
    for (int i = 0; i < NSLOT; i++)
      if (!bk_valid[i]) begin f = i; break; end
    if (f < 0) begin push_event(EV_REJECTED, id, 0, 0, 0, 0, RJ_FULL); return; end
    bk_valid[f] = 1'b1;
    bk_id[f] = id;
    bk_side[f] = side;
    bk_price[f] = 31'(price);
    bk_qty[f] = rem[30:0];
    bk_arr[f] = arr_count;
    arr_count++;
    push_event(EV_ACCEPTED, id, 0, 0, 0, 0, 3'd0);
    push_event(EV_BOOK, id, 0, side, 31'(price), level_sum(side, 31'(price)), 3'd0);
  endfunction

  function automatic void pull_order(logic [31:0] id);
    int s;
    s = find_order(id);
    if (s < 0) begin push_event(EV_REJECTED, id, 0, 0, 0, 0, RJ_UNK); return; end
    bk_valid[s] = 1'b0;
    push_event(EV_CANCELLED, id, 0, 0, 0, 35'(bk_qty[s]), 3'd0);
    push_event(EV_BOOK, id, 0, bk_side[s], bk_price[s], level_sum(bk_side[s], bk_price[s]),
               3'd0);
  endfunction

  function automatic void book_predict(in_t it);
    longint price;
    longint qty;
    int s;
    logic oside;
    logic [30:0] oprice;
    price = longint'(it.order_price);
    qty = longint'(it.order_quantity);
    step_events.delete();
    case (it.action)
      ACT_ADD_LIMIT: place_limit(it.order_id, it.order_side, price, qty);
      ACT_ADD_MARKET: begin
        if (find_order(it.order_id) >= 0)
          push_event(EV_REJECTED, it.order_id, 0, 0, 0, 0, RJ_DUP);
        else if (qty <= 0) push_event(EV_REJECTED, it.order_id, 0, 0, 0, 0, RJ_BADQ);
        else void'(cross_book(it.order_id, it.order_side, 1'b0, 0, 32'(qty)));
      end
      ACT_CANCEL: pull_order(it.order_id);
      ACT_MODIFY: begin
        s = find_order(it.order_id);
        if (s < 0) push_event(EV_REJECTED, it.order_id, 0, 0, 0, 0, RJ_UNK);
        else if (qty <= 0) push_event(EV_REJECTED, it.order_id, 0, 0, 0, 0, RJ_BADQ);
        else begin
          oside = bk_side[s];
          oprice = bk_price[s];
          if (price == longint'(oprice) && qty <= longint'(bk_qty[s])) begin
            bk_qty[s] = 31'(qty);
            push_event(EV_MODIFIED, it.order_id, 0, 0, 0, 35'(qty), 3'd0);
            push_event(EV_BOOK, it.order_id, 0, oside, oprice, level_sum(oside, oprice), 3'd0);
          end else begin
            bk_valid[s] = 1'b0;
            push_event(EV_BOOK, it.order_id, 0, oside, oprice, level_sum(oside, oprice), 3'd0);
            place_limit(it.order_id, oside, price, qty);
          end
        end
      end
      ACT_REDUCE: begin
        s = find_order(it.order_id);
        if (s < 0) push_event(EV_REJECTED, it.order_id, 0, 0, 0, 0, RJ_UNK);
        else if (qty <= 0) push_event(EV_REJECTED, it.order_id, 0, 0, 0, 0, RJ_BADQ);
        else if (longint'(bk_qty[s]) < qty)
          push_event(EV_REJECTED, it.order_id, 0, 0, 0, 0, RJ_INSUF);
        else begin
          bk_qty[s] -= 31'(qty);
          if (bk_qty[s] == 0) bk_valid[s] = 1'b0;
          push_event(EV_BOOK, it.order_id, 0, bk_side[s], bk_price[s],
                     level_sum(bk_side[s], bk_price[s]), 3'd0);
        end
      end
      ACT_REPLACE: begin
        s = find_order(it.order_id);
        if (s >= 0) begin
          oside = bk_side[s];
          pull_order(it.order_id);
          place_limit(it.new_order_id, oside, price, qty);
        end
      end
      default: ;
    endcase
    if (step_events.size() > 0) step_events[$].last_event = 1'b1;
    foreach (step_events[i]) pending_events.insert(pending_events.size(), step_events[i]);
  endfunction

  function automatic int pick_gap(int maxg);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, maxg * 8);
    return $urandom_range(0, maxg);
  endfunction

  task automatic send_order(in_t it);
    repeat (pick_gap(in_gap_max) + 1) @(posedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book_predict(it);
    n_items++;
    in_valid <= 1'b0;
  endtask

  // result side: random stalls, compare each transfer with the oldest expectation
  initial begin
    int g;
    out_t exp_ev;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      g = (out_gap_max == 0) ? 0 : pick_gap(out_gap_max);
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      n_events++;
      if (pending_events.size() == 0) begin
        errors++;
        $display("%0t unexpected event: actual %p", $time, out_item);
      end else begin
        exp_ev = pending_events[0];
        pending_events.delete(0);
        if (exp_ev.event_kind == EV_FILL) n_fills++;
        if (out_item !== exp_ev) begin
          errors++;
          $display("%0t event mismatch: expected %p actual %p", $time, exp_ev, out_item);
        end
      end
    end
  end

  function automatic in_t mk(logic [2:0] act, logic [31:0] id, logic side, int price, int qty,
                            logic [31:0] nid = 32'd0);
    in_t it;
    it.action = act;
    it.order_id = id;
    it.new_order_id = nid;
    it.order_side = side;
    it.order_price = price;
    it.order_quantity = qty;
    return it;
  endfunction

  task automatic drain_book();
    while (pending_events.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic test_rejects();
    send_order(mk(ACT_ADD_LIMIT, 32'd1, 0, 100, 10));
    send_order(mk(ACT_ADD_LIMIT, 32'd1, 1, 100, 10));
    send_order(mk(ACT_ADD_LIMIT, 32'd2, 0, 100, 0));
    send_order(mk(ACT_ADD_LIMIT, 32'd2, 0, 100, 32'h80000000));
    send_order(mk(ACT_ADD_LIMIT, 32'd2, 1, 0, 5));
    send_order(mk(ACT_ADD_LIMIT, 32'hFFFFFFFF, 1, 32'h80000000, 5));
    send_order(mk(ACT_ADD_MARKET, 32'd1, 1, 0, 5));
    send_order(mk(ACT_ADD_MARKET, 32'd3, 1, 0, -1));
    send_order(mk(ACT_CANCEL, 32'd99, 0, 0, 0));
    send_order(mk(ACT_MODIFY, 32'd99, 0, 1, 1));
    send_order(mk(ACT_MODIFY, 32'd1, 0, 100, 0));
    send_order(mk(ACT_REDUCE, 32'd99, 0, 0, 1));
    send_order(mk(ACT_REDUCE, 32'd1, 0, 0, -5));
    send_order(mk(ACT_REDUCE, 32'd1, 0, 0, 11));
    send_order(mk(ACT_REPLACE, 32'd99, 0, 5, 5, 32'd7));
    send_order(mk(3'd6, 32'd1, 0, 5, 5));
    send_order(mk(3'd7, 32'd1, 1, 5, 5));
  endtask

  task automatic test_matching();
    send_order(mk(ACT_ADD_LIMIT, 32'd10, 1, 32'h7FFFFFFF, 32'h7FFFFFFF));
    send_order(mk(ACT_ADD_LIMIT, 32'd11, 1, 100, 5));
    send_order(mk(ACT_ADD_LIMIT, 32'd12, 1, 100, 7));
    send_order(mk(ACT_MODIFY, 32'd11, 0, 100, 3));
    send_order(mk(ACT_MODIFY, 32'd12, 0, 101, 9));
    send_order(mk(ACT_ADD_LIMIT, 32'd13, 0, 101, 20));
    send_order(mk(ACT_ADD_MARKET, 32'd14, 0, 0, 32'h7FFFFFFF));
    send_order(mk(ACT_REDUCE, 32'd13, 0, 0, 1));
    send_order(mk(ACT_REPLACE, 32'd13, 0, 50, 4, 32'd15));
    send_order(mk(ACT_MODIFY, 32'd15, 0, -3, 4));
    send_order(mk(ACT_REDUCE, 32'd1, 0, 0, 10));
    drain_book();
  endtask

  task automatic test_store_full();
    for (int i = 0; i < NSLOT + 1; i++)
      send_order(mk(ACT_ADD_LIMIT, 32'(100 + i), 0, 10 + (i % 3), 1 + i));
    send_order(mk(ACT_ADD_MARKET, 32'd200, 1, 0, 1000));
    drain_book();
  endtask

  task automatic test_random_flow(int count);
    logic [31:0] ids[$];
    logic [31:0] id;
    in_t it;
    int r;
    for (int n = 0; n < count; n++) begin
      if (n == count / 3) begin in_gap_max = 0; out_gap_max = 0; end
      if (n == count / 2) begin in_gap_max = 4; out_gap_max = 6; end
      r = $urandom_range(0, 99);
      id = (ids.size() > 0 && $urandom_range(0, 2) != 0) ? ids[$urandom_range(0, ids.size() - 1)]
                                                         : 32'($urandom_range(1, 60));
      if ($urandom_range(0, 30) == 0) id = $urandom;
      it = mk(ACT_ADD_LIMIT, id, 1'($urandom_range(0, 1)), $urandom_range(95, 105),
              $urandom_range(1, 40), 32'($urandom_range(1, 60)));
      if (r < 45) it.action = ACT_ADD_LIMIT;
      else if (r < 55) it.action = ACT_ADD_MARKET;
      else if (r < 67) it.action = ACT_CANCEL;
      else if (r < 79) it.action = ACT_MODIFY;
      else if (r < 89) it.action = ACT_REDUCE;
      else if (r < 97) it.action = ACT_REPLACE;
      else it.action = 3'($urandom_range(6, 7));
      if ($urandom_range(0, 15) == 0) it.order_price = $urandom;
      if ($urandom_range(0, 15) == 0) it.order_quantity = $urandom;
      if ($urandom_range(0, 20) == 0) it.new_order_id = $urandom;
      if (it.action == ACT_ADD_LIMIT) ids.insert(ids.size(), id);
      if (it.action == ACT_REPLACE) ids.insert(ids.size(), it.new_order_id);
      if (ids.size() > 40) ids.delete(0);
      send_order(it);
    end
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      bk_valid[i] = 1'b0;
      bk_id[i] = '0;
      bk_side[i] = 1'b0;
      bk_price[i] = '0;
      bk_qty[i] = '0;
      bk_arr[i] = '0;
    end
    arr_count = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_rejects();
    test_matching();
    test_store_full();
    test_random_flow(160);
    drain_book();
    $display("%0d orders sent, %0d events checked (%0d fills), %0d left unmatched",
             n_items, n_events, n_fills, pending_events.size());
    if (errors == 0 && pending_events.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
src/obm_pkg.sv
src/obm_ram.sv
src/limit_order_book_matcher_core.sv
tb/tb_top.sv
